// ===== hdl/sao_pkg.sv =====
// ----------------------------------------------------------------------------
// Separating axis overlap package
// Shared sizes, codes and structures of the separating axis overlap unit.
// ----------------------------------------------------------------------------
package sao_pkg;

   // Store capacities.
   localparam int MAX_AXES     = 16;
   localparam int MAX_VERTICES = 8;

   localparam int AXIS_IDX_W = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
   localparam int VERT_IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int AXIS_CNT_W = $clog2(MAX_AXES + 1);
   localparam int VERT_CNT_W = $clog2(MAX_VERTICES + 1);

   // Arithmetic widths. A projection is the sum of two 16x16 products, an
   // overlap the difference of two projections, and an offset product is an
   // axis component times a non-negative overlap.
   localparam int COORD_W    = 16;
   localparam int TERM_W     = 32;
   localparam int PROJ_W     = 33;
   localparam int OVL_W      = 34;
   localparam int PROD_W     = COORD_W + OVL_W;
   localparam int OFFS_W     = 32;
   localparam int OFFS_SHIFT = 28;

   typedef enum logic [1:0] {
      OP_LOAD_AXIS   = 2'd0,
      OP_LOAD_FIRST  = 2'd1,
      OP_LOAD_SECOND = 2'd2,
      OP_COMPUTE     = 2'd3
   } sao_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MULX,
      ST_MULY,
      ST_ACC,
      ST_OVL,
      ST_CMP,
      ST_OFFX,
      ST_OFFY,
      ST_OFFW,
      ST_DONE
   } sao_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } sao_vec_type;

   typedef struct packed {
      logic        valid;
      sao_op_type  op;
      sao_vec_type vec;
   } sao_load_type;

   typedef struct packed {
      logic [AXIS_CNT_W-1:0] axis_cnt;
      logic [VERT_CNT_W-1:0] first_cnt;
      logic [VERT_CNT_W-1:0] second_cnt;
      logic                  overflow;
   } sao_stat_type;

endpackage

// ===== hdl/separating_axis_overlap_unit.sv =====
// ----------------------------------------------------------------------------
// Separating axis overlap unit
// Two-dimensional separating axis test with minimum translation vector,
// built around one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Ports       | Payload (lowest bits first)
//  --------+-------------+---------------------------------------------------
//  request | req_t*      | tdata: coord_x[15:0], coord_y[31:16]; tuser: opcode
//  result  | rsp_t*      | tdata: offset_x[31:0], offset_y[63:32];
//          |             | tuser: collision[0], overflow[1]
//
// A load transfer (opcode 0, 1 or 2) produces no result. A compute transfer
// runs the sequencer over the stored axes until one separates the shapes:
// each vertex takes a read, two products and an accumulate step, each axis
// then an overlap and a compare step, and an axis that becomes the best so
// far also the offset x, offset y and offset write steps. Reset is
// synchronous and active high; it empties all stores and drops a pending
// result. The request side is not ready while a compute runs; a finished
// result waits in the output register and does not block loads, only the
// end of the next compute.
//
module separating_axis_overlap_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // coord_x[15:0], coord_y[31:16]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // offset_x[31:0], offset_y[63:32]
   output logic [1:0]  rsp_tuser    // collision[0], overflow[1]
);

   localparam int PW = sao_pkg::PROJ_W;
   localparam int OW = sao_pkg::OVL_W;

   sao_pkg::sao_state_type state_ff, state_in;

   logic [sao_pkg::AXIS_CNT_W-1:0] axis_idx_ff, axis_idx_in;
   logic [sao_pkg::VERT_CNT_W-1:0] vert_idx_ff, vert_idx_in;
   logic                           shape_ff, shape_in;
   logic signed [sao_pkg::TERM_W-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [PW-1:0] lo1_ff, lo1_in, hi1_ff, hi1_in;
   logic signed [OW-1:0] ov_ff, ov_in, best_ff, best_in;
   logic                 have_best_ff, have_best_in;
   logic                 hit_ff, hit_in;
   logic signed [sao_pkg::OFFS_W-1:0] offx_ff, offx_in, offy_ff, offy_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_collision_ff, rsp_collision_in;
   logic                              rsp_overflow_ff, rsp_overflow_in;
   logic signed [sao_pkg::OFFS_W-1:0] rsp_offx_ff, rsp_offx_in;
   logic signed [sao_pkg::OFFS_W-1:0] rsp_offy_ff, rsp_offy_in;

   sao_pkg::sao_load_type load;
   sao_pkg::sao_stat_type stat;
   sao_pkg::sao_vec_type  axis_rd, first_rd, second_rd, vert_rd;
   logic                  done_fire;

   logic signed [sao_pkg::COORD_W-1:0] mul_a;
   logic signed [OW-1:0]               mul_b;
   logic signed [sao_pkg::PROD_W-1:0]  prod;

   logic signed [sao_pkg::TERM_W-1:0] prod_term;
   logic signed [sao_pkg::PROD_W-sao_pkg::OFFS_SHIFT-1:0] prod_scaled;
   logic signed [sao_pkg::OFFS_W-1:0] offs_val;
   logic signed [PW-1:0] proj, lo_nx, hi_nx;
   logic signed [OW-1:0] d1, d2, ov_nx;
   logic [sao_pkg::VERT_CNT_W-1:0] vert_cnt_sel;
   logic                           vert_last, axis_last;
   logic                           req_fire;

   // Loads go straight to the stores while the sequencer is idle.
   assign req_tready = (state_ff == sao_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load.valid = req_fire;
   assign load.op    = sao_pkg::sao_op_type'(req_tuser);
   assign load.vec.x = req_tdata[15:0];
   assign load.vec.y = req_tdata[31:16];

   assign done_fire = (state_ff == sao_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   sao_store u_store (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .clear     (done_fire),
      .axis_idx  (axis_idx_ff[sao_pkg::AXIS_IDX_W-1:0]),
      .vert_idx  (vert_idx_ff[sao_pkg::VERT_IDX_W-1:0]),
      .axis_rd   (axis_rd),
      .first_rd  (first_rd),
      .second_rd (second_rd),
      .stat      (stat)
   );

   sao_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   // Datapath around the shared multiplier.
   always_comb begin
      vert_rd      = shape_ff ? second_rd : first_rd;
      vert_cnt_sel = shape_ff ? stat.second_cnt : stat.first_cnt;
      vert_last    = ((vert_idx_ff + sao_pkg::VERT_CNT_W'(1)) == vert_cnt_sel);
      axis_last    = ((axis_idx_ff + sao_pkg::AXIS_CNT_W'(1)) == stat.axis_cnt);

      // The y component is used on the second product of each pair.
      if (state_ff == sao_pkg::ST_MULY || state_ff == sao_pkg::ST_OFFY) begin
         mul_a = axis_rd.y;
      end else begin
         mul_a = axis_rd.x;
      end
      case (state_ff)
         sao_pkg::ST_MULX: mul_b = OW'(vert_rd.x);
         sao_pkg::ST_MULY: mul_b = OW'(vert_rd.y);
         default:          mul_b = ov_ff;
      endcase

      // A projection term always fits 32 bits; the sum of two needs 33.
      prod_term = prod[sao_pkg::TERM_W-1:0];
      proj      = PW'(acc_ff) + PW'(prod_term);
      lo_nx     = (vert_idx_ff == '0 || proj < lo_ff) ? proj : lo_ff;
      hi_nx     = (vert_idx_ff == '0 || proj > hi_ff) ? proj : hi_ff;

      d1    = OW'(hi1_ff) - OW'(lo_ff);
      d2    = OW'(hi_ff) - OW'(lo1_ff);
      ov_nx = (d2 < d1) ? d2 : d1;

      // Arithmetic shift by 28 rounds toward minus infinity. The overlap is
      // never negative here and below 2^33, so the shifted value stays
      // within 22 bits and never reaches the 32-bit saturation limits.
      prod_scaled = prod[sao_pkg::PROD_W-1:sao_pkg::OFFS_SHIFT];
      offs_val    = sao_pkg::OFFS_W'(prod_scaled);
   end

   // Sequencer: next state and register updates.
   always_comb begin
      state_in     = state_ff;
      axis_idx_in  = axis_idx_ff;
      vert_idx_in  = vert_idx_ff;
      shape_in     = shape_ff;
      acc_in       = acc_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      lo1_in       = lo1_ff;
      hi1_in       = hi1_ff;
      ov_in        = ov_ff;
      best_in      = best_ff;
      have_best_in = have_best_ff;
      hit_in       = hit_ff;
      offx_in      = offx_ff;
      offy_in      = offy_ff;

      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_collision_in = rsp_collision_ff;
      rsp_overflow_in  = rsp_overflow_ff;
      rsp_offx_in      = rsp_offx_ff;
      rsp_offy_in      = rsp_offy_ff;

      case (state_ff)
         sao_pkg::ST_IDLE: begin
            if (req_fire && load.op == sao_pkg::OP_COMPUTE) begin
               axis_idx_in  = '0;
               vert_idx_in  = '0;
               shape_in     = 1'b0;
               have_best_in = 1'b0;
               offx_in      = '0;
               offy_in      = '0;
               if (stat.axis_cnt == '0) begin
                  // Nothing to test against: the shapes count as touching.
                  hit_in   = 1'b1;
                  state_in = sao_pkg::ST_DONE;
               end else if (stat.first_cnt == '0 || stat.second_cnt == '0) begin
                  hit_in   = 1'b0;
                  state_in = sao_pkg::ST_DONE;
               end else begin
                  hit_in   = 1'b1;
                  state_in = sao_pkg::ST_LOAD;
               end
            end
         end
         sao_pkg::ST_LOAD: begin
            state_in = sao_pkg::ST_MULX;
         end
         sao_pkg::ST_MULX: begin
            state_in = sao_pkg::ST_MULY;
         end
         sao_pkg::ST_MULY: begin
            acc_in   = prod_term;
            state_in = sao_pkg::ST_ACC;
         end
         sao_pkg::ST_ACC: begin
            lo_in = lo_nx;
            hi_in = hi_nx;
            if (!vert_last) begin
               vert_idx_in = vert_idx_ff + sao_pkg::VERT_CNT_W'(1);
               state_in    = sao_pkg::ST_LOAD;
            end else if (!shape_ff) begin
               lo1_in      = lo_nx;
               hi1_in      = hi_nx;
               shape_in    = 1'b1;
               vert_idx_in = '0;
               state_in    = sao_pkg::ST_LOAD;
            end else begin
               state_in = sao_pkg::ST_OVL;
            end
         end
         sao_pkg::ST_OVL: begin
            ov_in    = ov_nx;
            state_in = sao_pkg::ST_CMP;
         end
         sao_pkg::ST_CMP: begin
            if (ov_ff < 0) begin
               // A separating axis ends the search.
               hit_in   = 1'b0;
               state_in = sao_pkg::ST_DONE;
            end else if (!have_best_ff || ov_ff < best_ff) begin
               best_in      = ov_ff;
               have_best_in = 1'b1;
               state_in     = sao_pkg::ST_OFFX;
            end else if (axis_last) begin
               state_in = sao_pkg::ST_DONE;
            end else begin
               axis_idx_in = axis_idx_ff + sao_pkg::AXIS_CNT_W'(1);
               vert_idx_in = '0;
               shape_in    = 1'b0;
               state_in    = sao_pkg::ST_LOAD;
            end
         end
         sao_pkg::ST_OFFX: begin
            state_in = sao_pkg::ST_OFFY;
         end
         sao_pkg::ST_OFFY: begin
            offx_in  = offs_val;
            state_in = sao_pkg::ST_OFFW;
         end
         sao_pkg::ST_OFFW: begin
            offy_in = offs_val;
            if (axis_last) begin
               state_in = sao_pkg::ST_DONE;
            end else begin
               axis_idx_in = axis_idx_ff + sao_pkg::AXIS_CNT_W'(1);
               vert_idx_in = '0;
               shape_in    = 1'b0;
               state_in    = sao_pkg::ST_LOAD;
            end
         end
         sao_pkg::ST_DONE: begin
            // Hold until the output register is free, then hand the result
            // over and empty the stores in the same cycle.
            if (done_fire) begin
               rsp_valid_in     = 1'b1;
               rsp_collision_in = hit_ff;
               rsp_overflow_in  = stat.overflow;
               rsp_offx_in      = hit_ff ? offx_ff : '0;
               rsp_offy_in      = hit_ff ? offy_ff : '0;
               state_in         = sao_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sao_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sao_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_idx_ff      <= axis_idx_in;
      vert_idx_ff      <= vert_idx_in;
      shape_ff         <= shape_in;
      acc_ff           <= acc_in;
      lo_ff            <= lo_in;
      hi_ff            <= hi_in;
      lo1_ff           <= lo1_in;
      hi1_ff           <= hi1_in;
      ov_ff            <= ov_in;
      best_ff          <= best_in;
      have_best_ff     <= have_best_in;
      hit_ff           <= hit_in;
      offx_ff          <= offx_in;
      offy_ff          <= offy_in;
      rsp_collision_ff <= rsp_collision_in;
      rsp_overflow_ff  <= rsp_overflow_in;
      rsp_offx_ff      <= rsp_offx_in;
      rsp_offy_ff      <= rsp_offy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_offy_ff, rsp_offx_ff};
   assign rsp_tuser  = {rsp_overflow_ff, rsp_collision_ff};

endmodule

// ===== hdl/sao_store.sv =====
// ----------------------------------------------------------------------------
// Separating axis overlap stores
// Axis and vertex memories with fill counts, sticky overflow and registered
// read ports addressed by the sequencer.
// ----------------------------------------------------------------------------
module sao_store (
   input  logic                              clock,
   input  logic                              reset,
   input  sao_pkg::sao_load_type             load,
   input  logic                              clear,
   input  logic [sao_pkg::AXIS_IDX_W-1:0]    axis_idx,
   input  logic [sao_pkg::VERT_IDX_W-1:0]    vert_idx,
   output sao_pkg::sao_vec_type              axis_rd,
   output sao_pkg::sao_vec_type              first_rd,
   output sao_pkg::sao_vec_type              second_rd,
   output sao_pkg::sao_stat_type             stat
);

   sao_pkg::sao_vec_type axis_mem_ff   [sao_pkg::MAX_AXES];
   sao_pkg::sao_vec_type first_mem_ff  [sao_pkg::MAX_VERTICES];
   sao_pkg::sao_vec_type second_mem_ff [sao_pkg::MAX_VERTICES];

   sao_pkg::sao_vec_type axis_rd_ff;
   sao_pkg::sao_vec_type first_rd_ff;
   sao_pkg::sao_vec_type second_rd_ff;

   logic [sao_pkg::AXIS_CNT_W-1:0] axis_cnt_ff;
   logic [sao_pkg::VERT_CNT_W-1:0] first_cnt_ff;
   logic [sao_pkg::VERT_CNT_W-1:0] second_cnt_ff;
   logic                           overflow_ff;

   logic axis_full;
   logic first_full;
   logic second_full;
   logic wr_axis;
   logic wr_first;
   logic wr_second;
   logic dropped;

   always_comb begin
      axis_full   = (axis_cnt_ff == sao_pkg::AXIS_CNT_W'(sao_pkg::MAX_AXES));
      first_full  = (first_cnt_ff == sao_pkg::VERT_CNT_W'(sao_pkg::MAX_VERTICES));
      second_full = (second_cnt_ff == sao_pkg::VERT_CNT_W'(sao_pkg::MAX_VERTICES));
      wr_axis     = 1'b0;
      wr_first    = 1'b0;
      wr_second   = 1'b0;
      dropped     = 1'b0;
      if (load.valid) begin
         case (load.op)
            sao_pkg::OP_LOAD_AXIS: begin
               wr_axis = !axis_full;
               dropped = axis_full;
            end
            sao_pkg::OP_LOAD_FIRST: begin
               wr_first = !first_full;
               dropped  = first_full;
            end
            sao_pkg::OP_LOAD_SECOND: begin
               wr_second = !second_full;
               dropped   = second_full;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         axis_cnt_ff   <= '0;
         first_cnt_ff  <= '0;
         second_cnt_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         if (wr_axis) begin
            axis_cnt_ff <= axis_cnt_ff + sao_pkg::AXIS_CNT_W'(1);
         end
         if (wr_first) begin
            first_cnt_ff <= first_cnt_ff + sao_pkg::VERT_CNT_W'(1);
         end
         if (wr_second) begin
            second_cnt_ff <= second_cnt_ff + sao_pkg::VERT_CNT_W'(1);
         end
         if (dropped) begin
            overflow_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_axis) begin
         axis_mem_ff[axis_cnt_ff[sao_pkg::AXIS_IDX_W-1:0]] <= load.vec;
      end
      if (wr_first) begin
         first_mem_ff[first_cnt_ff[sao_pkg::VERT_IDX_W-1:0]] <= load.vec;
      end
      if (wr_second) begin
         second_mem_ff[second_cnt_ff[sao_pkg::VERT_IDX_W-1:0]] <= load.vec;
      end
      axis_rd_ff   <= axis_mem_ff[axis_idx];
      first_rd_ff  <= first_mem_ff[vert_idx];
      second_rd_ff <= second_mem_ff[vert_idx];
   end

   assign axis_rd         = axis_rd_ff;
   assign first_rd        = first_rd_ff;
   assign second_rd       = second_rd_ff;
   assign stat.axis_cnt   = axis_cnt_ff;
   assign stat.first_cnt  = first_cnt_ff;
   assign stat.second_cnt = second_cnt_ff;
   assign stat.overflow   = overflow_ff;

endmodule

// ===== hdl/sao_mul.sv =====
// ----------------------------------------------------------------------------
// Separating axis overlap multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module sao_mul (
   input  logic                               clock,
   input  logic signed [sao_pkg::COORD_W-1:0] mul_a,
   input  logic signed [sao_pkg::OVL_W-1:0]   mul_b,
   output logic signed [sao_pkg::PROD_W-1:0]  prod
);

   logic signed [sao_pkg::PROD_W-1:0] a_ext;
   logic signed [sao_pkg::PROD_W-1:0] b_ext;
   logic signed [sao_pkg::PROD_W-1:0] prod_in;
   logic signed [sao_pkg::PROD_W-1:0] prod_ff;

   always_comb begin
      a_ext   = sao_pkg::PROD_W'(mul_a);
      b_ext   = sao_pkg::PROD_W'(mul_b);
      prod_in = a_ext * b_ext;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule
